FILE: rtl/core/lcm_pkg.sv
// Package for the least common multiple block: transaction structs, widths,
// sequencer states and the status bundle passed between core and top level.
// No dependencies.
`default_nettype none

package lcm_pkg;

  // Operand bits taken into account (low bits of each 16-bit field)
  localparam int WIDTH = 16;
  localparam int IN_W  = 16;
  localparam int OUT_W = 32;
  localparam int OPW   = (WIDTH < IN_W) ? WIDTH : IN_W;
  // Product width and shift-count width
  localparam int MW    = 2 * OPW;
  localparam int KW    = $clog2(OPW);

  typedef struct packed {
    logic [IN_W-1:0] operand_a;
    logic [IN_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] multiple;
    logic             error;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lcm_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/lcm_core.sv
// Iterative least common multiple core: binary GCD, restoring division of
// operand a by the GCD, then shift-add multiply by operand b, all on one
// shared add/subtract unit. Depends on lcm_pkg.
`default_nettype none

module lcm_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire lcm_pkg::in_t      opnd,
  input  wire logic              ack,
  output lcm_pkg::lcm_stat_t     stat,
  output lcm_pkg::out_t          res
);

  lcm_pkg::state_t state_r, state_nxt;

  logic [lcm_pkg::OPW-1:0] a_r, a_nxt;
  logic [lcm_pkg::OPW-1:0] b_r, b_nxt;
  logic [lcm_pkg::OPW-1:0] u_r, u_nxt;
  logic [lcm_pkg::OPW-1:0] v_r, v_nxt;
  logic [lcm_pkg::OPW-1:0] g_r, g_nxt;
  logic [lcm_pkg::OPW-1:0] quo_r, quo_nxt;
  logic [lcm_pkg::OPW-1:0] rem_r, rem_nxt;
  logic [lcm_pkg::KW-1:0]  k_r, k_nxt;
  logic [lcm_pkg::KW-1:0]  cnt_r, cnt_nxt;
  logic [lcm_pkg::MW-1:0]  acc_r, acc_nxt;
  logic [lcm_pkg::MW-1:0]  mcand_r, mcand_nxt;
  logic                    err_r, err_nxt;

  // Shared add/subtract unit
  logic [lcm_pkg::MW-1:0]  alu_x, alu_y;
  logic                    alu_sub;
  logic [lcm_pkg::MW:0]    alu_sum;

  logic [lcm_pkg::OPW-1:0] in_a, in_b;
  logic                    in_zero;
  logic                    u_gt_v;
  logic                    gcd_found;
  logic [lcm_pkg::OPW:0]   rem_sh;
  logic                    cnt_last;

  assign in_a      = opnd.operand_a[lcm_pkg::OPW-1:0];
  assign in_b      = opnd.operand_b[lcm_pkg::OPW-1:0];
  assign in_zero   = (in_a == '0) || (in_b == '0);
  assign u_gt_v    = (u_r > v_r);
  assign gcd_found = u_r[0] && v_r[0] && (u_r == v_r);
  assign rem_sh    = {rem_r, quo_r[lcm_pkg::OPW-1]};
  assign cnt_last  = (cnt_r == '0);

  assign alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                 + {{lcm_pkg::MW{1'b0}}, alu_sub};

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcm_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = in_zero ? lcm_pkg::ST_DONE : lcm_pkg::ST_GCD;
        end
      end
      lcm_pkg::ST_GCD: begin
        if (gcd_found) begin
          state_nxt = lcm_pkg::ST_DIV;
        end
      end
      lcm_pkg::ST_DIV: begin
        if (cnt_last) begin
          state_nxt = lcm_pkg::ST_MUL;
        end
      end
      lcm_pkg::ST_MUL: begin
        if (cnt_last) begin
          state_nxt = lcm_pkg::ST_DONE;
        end
      end
      lcm_pkg::ST_DONE: begin
        if (ack) begin
          state_nxt = lcm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lcm_pkg::ST_IDLE;
    endcase
  end

  // Drive status and steer the shared unit per state
  always_comb begin
    stat.idle = 1'b0;
    stat.done = 1'b0;
    alu_x     = '0;
    alu_y     = '0;
    alu_sub   = 1'b0;
    unique case (state_r)
      lcm_pkg::ST_IDLE: begin
        stat.idle = 1'b1;
      end
      lcm_pkg::ST_GCD: begin
        alu_x   = lcm_pkg::MW'(u_gt_v ? u_r : v_r);
        alu_y   = lcm_pkg::MW'(u_gt_v ? v_r : u_r);
        alu_sub = 1'b1;
      end
      lcm_pkg::ST_DIV: begin
        alu_x   = lcm_pkg::MW'(rem_sh);
        alu_y   = lcm_pkg::MW'(g_r);
        alu_sub = 1'b1;
      end
      lcm_pkg::ST_MUL: begin
        alu_x   = acc_r;
        alu_y   = mcand_r;
      end
      lcm_pkg::ST_DONE: begin
        stat.done = 1'b1;
      end
      default: begin
        stat.idle = 1'b0;
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    g_nxt     = g_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    err_nxt   = err_r;
    unique case (state_r)
      lcm_pkg::ST_IDLE: begin
        if (start) begin
          a_nxt   = in_a;
          b_nxt   = in_b;
          u_nxt   = in_a;
          v_nxt   = in_b;
          k_nxt   = '0;
          acc_nxt = '0;
          err_nxt = in_zero;
        end
      end
      lcm_pkg::ST_GCD: begin
        // Binary GCD: strip common twos, then odd-odd subtract and halve
        priority if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (gcd_found) begin
          g_nxt   = u_r << k_r;
          quo_nxt = a_r;
          rem_nxt = '0;
          cnt_nxt = lcm_pkg::KW'(lcm_pkg::OPW - 1);
        end else if (u_gt_v) begin
          u_nxt = {1'b0, alu_sum[lcm_pkg::OPW-1:1]};
        end else begin
          v_nxt = {1'b0, alu_sum[lcm_pkg::OPW-1:1]};
        end
      end
      lcm_pkg::ST_DIV: begin
        // Restoring division, one quotient bit per cycle
        if (alu_sum[lcm_pkg::MW]) begin
          rem_nxt = alu_sum[lcm_pkg::OPW-1:0];
        end else begin
          rem_nxt = rem_sh[lcm_pkg::OPW-1:0];
        end
        quo_nxt = {quo_r[lcm_pkg::OPW-2:0], alu_sum[lcm_pkg::MW]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_last) begin
          acc_nxt   = '0;
          mcand_nxt = lcm_pkg::MW'(b_r);
          cnt_nxt   = lcm_pkg::KW'(lcm_pkg::OPW - 1);
        end
      end
      lcm_pkg::ST_MUL: begin
        // Shift-add multiply of the quotient by operand b
        if (quo_r[0]) begin
          acc_nxt = alu_sum[lcm_pkg::MW-1:0];
        end
        quo_nxt   = quo_r >> 1;
        mcand_nxt = mcand_r << 1;
        cnt_nxt   = cnt_r - 1'b1;
      end
      lcm_pkg::ST_DONE: begin
        err_nxt = err_r;
      end
      default: begin
        err_nxt = err_r;
      end
    endcase
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    g_r     <= g_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    k_r     <= k_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    err_r   <= err_nxt;
  end

  assign res.multiple = lcm_pkg::OUT_W'(acc_r);
  assign res.error    = err_r;

endmodule

`default_nettype wire

FILE: rtl/core/least_common_multiple_top.sv
// Sequence: when an operand is zero the core goes straight to its done state.
// Otherwise a binary GCD phase, a division phase and a multiply phase run on one
// shared adder, and the result is then loaded into the output register.
// One transaction at a time; in_ready is high only while the core is idle.
// A finished result waits in the output register, so the next transaction
// is taken while it does. Reset (synchronous, rst_n low) idles all.
`default_nettype none

module least_common_multiple_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lcm_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output lcm_pkg::out_t      out_data
);

  lcm_pkg::lcm_stat_t stat;
  lcm_pkg::out_t      res;
  lcm_pkg::out_t      out_r;
  logic               out_valid_r, out_valid_nxt;
  logic               load;

  lcm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_valid && in_ready),
    .opnd  (in_data),
    .ack   (load),
    .stat  (stat),
    .res   (res)
  );

  // Move a finished result into the output register when it is free
  assign load     = stat.done && (!out_valid_r || out_ready);
  assign in_ready = stat.idle;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: rtl/core/lcm_checker.sv
// Port-level checker for least_common_multiple_top, bound to the top level.
// Depends on lcm_pkg.
`default_nettype none

module lcm_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire lcm_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire lcm_pkg::out_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Error result carries zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.multiple == '0)
    else $error("error result with nonzero multiple");

  // Valid result is never zero
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.error |-> out_data.multiple != '0)
    else $error("valid result is zero");

  // Busy right after taking a transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind least_common_multiple_top lcm_checker u_lcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for least_common_multiple_top: drives operand pairs
// over a valid/ready channel and compares every result with a local LCM model.
// Depends on lcm_pkg and the least_common_multiple_top RTL.
`default_nettype none

module testbench;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lcm_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lcm_pkg::out_t out_data;

  // Expected results, oldest first
  lcm_pkg::out_t lcm_expected[$];

  int cycle_count = 0;
  int fail_count = 0;
  int sent_count = 0;
  int zero_count = 0;
  int checked_count = 0;
  // Random idling on both sides when set
  bit idle_on = 1'b1;
  // Long receiver hold-off requested by a test, in cycles
  int rx_hold_cycles = 0;

  least_common_multiple_top u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // Clock: period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Expected LCM of one operand pair, saturated to 32 bits, zero flags an error
  function automatic lcm_pkg::out_t compute_lcm(input lcm_pkg::in_t item);
    longint unsigned mask;
    longint unsigned a;
    longint unsigned b;
    longint unsigned x;
    longint unsigned y;
    longint unsigned r;
    longint unsigned m;
    lcm_pkg::out_t res;
    mask = (lcm_pkg::WIDTH >= lcm_pkg::IN_W) ? 64'hFFFF
                                             : ((64'd1 << lcm_pkg::WIDTH) - 64'd1);
    a = longint'(item.operand_a) & mask;
    b = longint'(item.operand_b) & mask;
    if (a == 0 || b == 0) begin
      res.multiple = '0;
      res.error = 1'b1;
      return res;
    end
    // Euclid on the masked operands
    x = a;
    y = b;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    m = (a / x) * b;
    if (m > 64'hFFFF_FFFF)
      m = 64'hFFFF_FFFF;
    res.multiple = m[lcm_pkg::OUT_W-1:0];
    res.error = 1'b0;
    return res;
  endfunction

  // Offer one transaction; valid stays high across back-to-back items
  task automatic send_operands(input logic [lcm_pkg::IN_W-1:0] a,
                               input logic [lcm_pkg::IN_W-1:0] b);
    int gap;
    lcm_pkg::in_t item;
    gap = idle_on ? int'($urandom_range(0, 15)) : 0;
    item.operand_a = a;
    item.operand_b = b;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lcm_expected.push_back(compute_lcm(item));
    sent_count++;
    if (a == 0 || b == 0)
      zero_count++;
  endtask

  // Receiver: random stalls, optional long hold-off, check each result
  initial begin : result_checker
    int stall;
    lcm_pkg::out_t exp_res;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? int'($urandom_range(0, 15)) : 0;
      stall += rx_hold_cycles;
      rx_hold_cycles = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      checked_count++;
      if (lcm_expected.size() == 0) begin
        $error("unexpected result: multiple %0d error %0b",
               out_data.multiple, out_data.error);
        fail_count++;
      end else begin
        exp_res = lcm_expected.pop_front();
        if (out_data.multiple !== exp_res.multiple) begin
          $error("multiple mismatch: expected %0d, actual %0d",
                 exp_res.multiple, out_data.multiple);
          fail_count++;
        end
        if (out_data.error !== exp_res.error) begin
          $error("error mismatch: expected %0b, actual %0b", exp_res.error, out_data.error);
          fail_count++;
        end
      end
    end
  end

  // Extremes, zero operands, coprime and shared-factor pairs
  task automatic test_directed();
    send_operands(16'd0, 16'd0);
    send_operands(16'd0, 16'd5);
    send_operands(16'd7, 16'd0);
    send_operands(16'hFFFF, 16'd0);
    send_operands(16'd1, 16'd1);
    send_operands(16'hFFFF, 16'hFFFF);
    send_operands(16'hFFFF, 16'hFFFE);
    send_operands(16'hFFFF, 16'd1);
    send_operands(16'd1, 16'hFFFF);
    send_operands(16'd65521, 16'd65519);
    send_operands(16'h8000, 16'h8000);
    send_operands(16'h8000, 16'd1);
    send_operands(16'h8000, 16'h7FFF);
    send_operands(16'd12, 16'd18);
    send_operands(16'd4, 16'd6);
    send_operands(16'd6, 16'd4);
    send_operands(16'd17, 16'd17);
    send_operands(16'hAAAA, 16'h5555);
    send_operands(16'h5555, 16'hAAAA);
    send_operands(16'd2, 16'd3);
    send_operands(16'd1024, 16'd96);
  endtask

  // Random pairs of several shapes; idling on both sides follows idle_on
  task automatic test_random_mix(input int count);
    logic [lcm_pkg::IN_W-1:0] a;
    logic [lcm_pkg::IN_W-1:0] b;
    int g;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: begin
          // zero in one or both operands
          a = $urandom_range(0, 2) == 0 ? '0 : lcm_pkg::IN_W'($urandom());
          b = (a != 0 || $urandom_range(0, 1)) ? '0 : lcm_pkg::IN_W'($urandom());
          if ($urandom_range(0, 1)) begin
            a ^= b;
            b ^= a;
            a ^= b;
          end
        end
        4, 5: begin
          a = lcm_pkg::IN_W'($urandom_range(1, 255));
          b = lcm_pkg::IN_W'($urandom_range(1, 255));
        end
        6, 7: begin
          // common factor
          g = $urandom_range(1, 255);
          a = lcm_pkg::IN_W'(g * $urandom_range(1, 65535 / g));
          b = lcm_pkg::IN_W'(g * $urandom_range(1, 65535 / g));
        end
        8: begin
          a = $urandom_range(0, 1) ? lcm_pkg::IN_W'(32'hFFFF - $urandom_range(0, 3))
                                   : lcm_pkg::IN_W'(32'd1 << $urandom_range(0, 15));
          b = $urandom_range(0, 1) ? lcm_pkg::IN_W'(32'hFFFF - $urandom_range(0, 3))
                                   : lcm_pkg::IN_W'(32'd1 << $urandom_range(0, 15));
        end
        9: begin
          a = lcm_pkg::IN_W'($urandom());
          b = a;
        end
        default: begin
          a = lcm_pkg::IN_W'($urandom());
          b = lcm_pkg::IN_W'($urandom());
        end
      endcase
      send_operands(a, b);
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    test_random_mix(count);
    idle_on = 1'b1;
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  task automatic test_output_stall(input int count);
    idle_on = 1'b0;
    rx_hold_cycles = 400;
    test_random_mix(count);
    idle_on = 1'b1;
  endtask

  initial begin : run_tests
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_mix(800);
    test_back_to_back(150);
    test_output_stall(40);
    test_random_mix(740);
    in_valid <= 1'b0;

    // Drain, then allow any stray result to show up
    while (lcm_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lcm_expected.size() != 0) begin
      $error("%0d expected results never arrived", lcm_expected.size());
      fail_count++;
    end

    $display("Sent %0d operand pairs (%0d with a zero operand), checked %0d results,",
             sent_count, zero_count, checked_count);
    $display("including back-to-back traffic and a long output stall.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
